FILE: hw/rtl/flsan_pkg.sv
package flsan_pkg;

  localparam logic [7:0] CH_SLASH      = 8'h2f;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5c;
  localparam logic [7:0] CH_DOT        = 8'h2e;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_LT         = 8'h3c;
  localparam logic [7:0] CH_GT         = 8'h3e;
  localparam logic [7:0] CH_COLON      = 8'h3a;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_PIPE       = 8'h7c;
  localparam logic [7:0] CH_QUESTION   = 8'h3f;
  localparam logic [7:0] CH_STAR       = 8'h2a;
  localparam logic [7:0] CH_DIGIT_1    = 8'h31;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7a;
  localparam logic [7:0] CTRL_LIMIT    = 8'h20;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  // UTF-8 lead byte ranges and code point limits
  localparam logic [7:0]  LEAD2_LO     = 8'hc2;
  localparam logic [7:0]  LEAD2_HI     = 8'hdf;
  localparam logic [7:0]  LEAD3_LO     = 8'he0;
  localparam logic [7:0]  LEAD3_HI     = 8'hef;
  localparam logic [7:0]  LEAD4_LO     = 8'hf0;
  localparam logic [7:0]  LEAD4_HI     = 8'hf4;
  localparam logic [20:0] MIN_CP3      = 21'h000800;
  localparam logic [20:0] MIN_CP4      = 21'h010000;
  localparam logic [20:0] SURR_LO      = 21'h00d800;
  localparam logic [20:0] SURR_HI      = 21'h00dfff;
  localparam logic [20:0] MAX_CP       = 21'h10ffff;

  // reserved device names, upper case, first char in the high byte
  localparam logic [23:0] NAME_CON = 24'h434f4e;
  localparam logic [23:0] NAME_PRN = 24'h50524e;
  localparam logic [23:0] NAME_AUX = 24'h415558;
  localparam logic [23:0] NAME_NUL = 24'h4e554c;
  localparam logic [23:0] NAME_COM = 24'h434f4d;
  localparam logic [23:0] NAME_LPT = 24'h4c5054;

  localparam int unsigned BASE_DEPTH = 4;
  localparam logic [2:0]  BASE_SAT   = 3'd5;

  // one accepted item as seen by the leaf trackers
  typedef struct packed {
    logic step;   // an item is accepted this cycle
    logic clear;  // separator or final byte: state returns to reset
  } leaf_ctl_t;

  function automatic logic is_separator(input logic [7:0] b);
    return (b == CH_SLASH) || (b == CH_BACKSLASH);
  endfunction

  function automatic logic is_forbidden(input logic [7:0] b);
    return (b < CTRL_LIMIT) || (b == CH_LT) || (b == CH_GT) || (b == CH_COLON) ||
           (b == CH_QUOTE) || (b == CH_SLASH) || (b == CH_BACKSLASH) ||
           (b == CH_PIPE) || (b == CH_QUESTION) || (b == CH_STAR);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ? (b - CASE_OFFSET) : b;
  endfunction

endpackage

FILE: hw/rtl/flsan_utf8.sv
module flsan_utf8 (
  input  logic                clk,
  input  logic                rst,
  input  flsan_pkg::leaf_ctl_t ctl,
  input  logic [7:0]          leaf_byte,
  input  logic                is_leaf,
  output logic                bad_next
);
  import flsan_pkg::*;

  logic [1:0]  pending, pending_next;
  logic [1:0]  seq_len, seq_len_next;
  logic [20:0] partial, partial_next;
  logic        enc_err, enc_err_next;
  logic [20:0] cp;

  assign cp = {partial[14:0], leaf_byte[5:0]};

  always_comb begin
    pending_next = pending;
    seq_len_next = seq_len;
    partial_next = partial;
    enc_err_next = enc_err;
    if (is_leaf && !enc_err) begin
      if (pending == 2'd0) begin
        if (leaf_byte[7] == 1'b0) begin
          pending_next = 2'd0;
        end else if (leaf_byte >= LEAD2_LO && leaf_byte <= LEAD2_HI) begin
          pending_next = 2'd1;
          seq_len_next = 2'd1;
          partial_next = {16'd0, leaf_byte[4:0]};
        end else if (leaf_byte >= LEAD3_LO && leaf_byte <= LEAD3_HI) begin
          pending_next = 2'd2;
          seq_len_next = 2'd2;
          partial_next = {17'd0, leaf_byte[3:0]};
        end else if (leaf_byte >= LEAD4_LO && leaf_byte <= LEAD4_HI) begin
          pending_next = 2'd3;
          seq_len_next = 2'd3;
          partial_next = {18'd0, leaf_byte[2:0]};
        end else begin
          enc_err_next = 1'b1;
        end
      end else if (leaf_byte[7:6] != 2'b10) begin
        enc_err_next = 1'b1;
        pending_next = 2'd0;
      end else begin
        partial_next = cp;
        pending_next = pending - 2'd1;
        // sequence closes: overlong, surrogate and range checks
        if (pending == 2'd1) begin
          if ((seq_len == 2'd2 && cp < MIN_CP3) || (seq_len == 2'd3 && cp < MIN_CP4) ||
              (cp >= SURR_LO && cp <= SURR_HI) || (cp > MAX_CP)) begin
            enc_err_next = 1'b1;
          end
        end
      end
    end
  end

  assign bad_next = enc_err_next || (pending_next != 2'd0);

  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.clear)) begin
      pending <= '0;
      seq_len <= '0;
      partial <= '0;
      enc_err <= 1'b0;
    end else if (ctl.step) begin
      pending <= pending_next;
      seq_len <= seq_len_next;
      partial <= partial_next;
      enc_err <= enc_err_next;
    end
  end

endmodule

FILE: hw/rtl/flsan_base.sv
module flsan_base (
  input  logic                clk,
  input  logic                rst,
  input  flsan_pkg::leaf_ctl_t ctl,
  input  logic [7:0]          leaf_byte,
  input  logic                is_leaf,
  output logic                reserved_next
);
  import flsan_pkg::*;

  logic [7:0] chars      [BASE_DEPTH];
  logic [7:0] chars_next [BASE_DEPTH];
  logic [2:0] count, count_next;
  logic       dot_seen, dot_seen_next;

  always_comb begin
    for (int i = 0; i < BASE_DEPTH; i++) begin
      chars_next[i] = chars[i];
    end
    count_next    = count;
    dot_seen_next = dot_seen;
    if (is_leaf && !dot_seen) begin
      if (leaf_byte == CH_DOT) begin
        dot_seen_next = 1'b1;
      end else begin
        if (count < 3'(BASE_DEPTH)) begin
          chars_next[count[1:0]] = to_upper(leaf_byte);
        end
        if (count < BASE_SAT) begin
          count_next = count + 3'd1;
        end
      end
    end
  end

  logic [23:0] head;
  assign head = {chars_next[0], chars_next[1], chars_next[2]};

  always_comb begin
    reserved_next = 1'b0;
    if (count_next == 3'd3) begin
      reserved_next = (head == NAME_CON) || (head == NAME_PRN) ||
                      (head == NAME_AUX) || (head == NAME_NUL);
    end else if (count_next == 3'd4) begin
      reserved_next = ((head == NAME_COM) || (head == NAME_LPT)) &&
                      (chars_next[3] >= CH_DIGIT_1) && (chars_next[3] <= CH_DIGIT_9);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.clear)) begin
      for (int i = 0; i < BASE_DEPTH; i++) begin
        chars[i] <= '0;
      end
      count    <= '0;
      dot_seen <= 1'b0;
    end else if (ctl.step) begin
      for (int i = 0; i < BASE_DEPTH; i++) begin
        chars[i] <= chars_next[i];
      end
      count    <= count_next;
      dot_seen <= dot_seen_next;
    end
  end

endmodule

FILE: hw/rtl/filename_leaf_utf8_sanitizer.sv
// Each accepted input item's result item is registered and shown on the master side in the cycle after it is accepted.
// Throughput: one item per cycle; the single output register is refilled in the same
// cycle its item is taken, so a stall only holds the input while a result waits.
// Reset (rst, synchronous, active high) clears all leaf state and empties the output
// register; no clearing pass, the block accepts items in the first cycle after reset.
module filename_leaf_utf8_sanitizer (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] path_byte
  input  logic        s_tlast,   // end_of_path
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [8] verdict, [15:9] zero
  output logic [1:0]  m_tuser,   // [0] byte_present, [1] leaf_restart
  output logic        m_tlast    // done_res
);
  import flsan_pkg::*;

  leaf_ctl_t  ctl;
  logic       accept;
  logic       sep;
  logic       is_leaf;
  logic       utf8_bad;
  logic       reserved;
  logic       unsafe;

  // output register may load whenever it is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign sep     = is_separator(s_tdata);
  assign is_leaf = !sep;

  // a separator or the final byte returns every tracker to its reset state
  assign ctl.step  = accept;
  assign ctl.clear = sep || s_tlast;

  flsan_utf8 u_utf8 (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .leaf_byte (s_tdata),
    .is_leaf   (is_leaf),
    .bad_next  (utf8_bad)
  );

  flsan_base u_base (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .leaf_byte     (s_tdata),
    .is_leaf       (is_leaf),
    .reserved_next (reserved)
  );

  // On a final leaf byte the leaf is non-empty and its last byte is the current one.
  // A final separator leaves an empty leaf, which is always unsafe.
  assign unsafe = sep || utf8_bad || reserved ||
                  (s_tdata == CH_DOT) || (s_tdata == CH_SPACE);

  logic [7:0] out_byte;
  logic       byte_present;
  logic       leaf_restart;
  logic       done_res;
  logic       verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte     <= sep ? 8'd0 : (is_forbidden(s_tdata) ? CH_UNDERSCORE : s_tdata);
      byte_present <= is_leaf;
      leaf_restart <= sep;
      done_res     <= s_tlast;
      verdict      <= s_tlast && unsafe;
    end
  end

  assign m_tdata = {7'd0, verdict, out_byte};
  assign m_tuser = {leaf_restart, byte_present};
  assign m_tlast = done_res;

endmodule

FILE: hw/rtl/flsan_checker.sv
module flsan_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import flsan_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("stalled result item changed");

  // a separator item carries no byte and restarts the leaf
  a_sep: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && ((s_tdata == CH_SLASH) || (s_tdata == CH_BACKSLASH))
    |=> m_tvalid && m_tuser[1] && !m_tuser[0] && (m_tdata[7:0] == 8'd0))
    else $error("separator item not reported as leaf restart");

  // a path ending in a separator has an empty leaf
  a_empty: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast &&
    ((s_tdata == CH_SLASH) || (s_tdata == CH_BACKSLASH))
    |=> m_tvalid && m_tlast && m_tdata[8])
    else $error("empty leaf judged safe");

  // verdict only on the final item
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !m_tdata[8])
    else $error("verdict raised before end of path");

  // forbidden characters never leave the block
  a_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !is_forbidden(m_tdata[7:0]))
    else $error("forbidden byte echoed");

endmodule

bind filename_leaf_utf8_sanitizer flsan_checker u_flsan_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
